### rtl/cr3_pkg.sv
`default_nettype none
package cr3_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
    localparam int T_SW            = PARAM_W + 1;
    localparam int CP_W            = 3 * COORD_WIDTH;
    localparam int CFG_IDX_W       = 2;

    localparam int A1_W = COORD_WIDTH + 1;
    localparam int A2_W = COORD_WIDTH + 4;
    localparam int A3_W = COORD_WIDTH + 3;
    localparam int H1_W = A2_W + 1;
    localparam int H2_W = H1_W + 1;
    localparam int H3_W = H2_W + 1;
    localparam int M1_W = A3_W + T_SW;
    localparam int M2_W = H1_W + T_SW;
    localparam int M3_W = H2_W + T_SW;

    localparam int PIPE_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P1 = 2'd0,
        CFG_P2 = 2'd1,
        CFG_P3 = 2'd2,
        CFG_P4 = 2'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

### rtl/catmull_rom_point_3d.sv
// Throughput: one request per cycle while the output is not stalled; eight
// register stages hold nine multipliers (one per Horner step and axis), the
// three rounding adds and the final saturation.
// The whole pipeline holds while a valid result is stalled at the output.
// Reset (synchronous, active low) clears the valid bits and all four control points.
`default_nettype none
module catmull_rom_point_3d (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [cr3_pkg::PARAM_W-1:0]           i_curve_param,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [cr3_pkg::COORD_WIDTH-1:0]     o_pos_x,
    output logic signed [cr3_pkg::COORD_WIDTH-1:0]     o_pos_y,
    output logic signed [cr3_pkg::COORD_WIDTH-1:0]     o_pos_z,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [cr3_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [cr3_pkg::CP_W-1:0]              i_cfg_data
);
    import cr3_pkg::*;

    localparam int HALF_T  = 2 ** (PARAM_FRAC_BITS - 1);
    localparam int ONE_T   = 2 ** PARAM_FRAC_BITS;
    localparam int SAT_MAX = (2 ** (COORD_WIDTH - 1)) - 1;
    localparam int SAT_MIN = -(2 ** (COORD_WIDTH - 1));

    logic [CP_W-1:0]              r_cp [4];
    logic signed [A1_W-1:0]       r_a0 [3];
    logic signed [A1_W-1:0]       r_a1 [3];
    logic signed [A2_W-1:0]       r_a2 [3];
    logic signed [A3_W-1:0]       r_a3 [3];

    logic signed [A2_W-1:0]       w_e  [4][3];

    logic [PIPE_DEPTH-1:0]        r_vld;
    logic [PARAM_W-1:0]           r_t  [5];
    logic [PARAM_W-1:0]           n_t;
    logic signed [M1_W-1:0]       r_m1 [3];
    logic signed [H1_W-1:0]       r_h1 [3];
    logic signed [M2_W-1:0]       r_m2 [3];
    logic signed [H2_W-1:0]       r_h2 [3];
    logic signed [M3_W-1:0]       r_m3 [3];
    logic signed [H3_W-1:0]       r_h3 [3];
    logic signed [COORD_WIDTH-1:0] r_pos [3];

    logic signed [M1_W-1:0]       w_r1 [3];
    logic signed [M2_W-1:0]       w_r2 [3];
    logic signed [M3_W-1:0]       w_r3 [3];
    logic signed [H3_W-1:0]       w_hr [3];
    logic signed [COORD_WIDTH-1:0] n_pos [3];

    logic                         en;

    assign o_cfg_ready = i_rst_n;
    assign en          = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall     = !en || !i_rst_n;
    assign o_valid     = r_vld[PIPE_DEPTH-1];
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cp[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_P1:  r_cp[0] <= i_cfg_data;
                CFG_P2:  r_cp[1] <= i_cfg_data;
                CFG_P3:  r_cp[2] <= i_cfg_data;
                CFG_P4:  r_cp[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int g = 0; g < 3; g++) begin
                w_e[k][g] = A2_W'($signed(r_cp[k][g*COORD_WIDTH +: COORD_WIDTH]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 3; g++) begin
            r_a0[g] <= A1_W'(w_e[1][g] <<< 1);
            r_a1[g] <= A1_W'(w_e[2][g] - w_e[0][g]);
            r_a2[g] <= (w_e[0][g] <<< 1) - ((w_e[1][g] <<< 2) + w_e[1][g])
                       + (w_e[2][g] <<< 2) - w_e[3][g];
            r_a3[g] <= A3_W'(w_e[3][g] - w_e[0][g] + (w_e[1][g] <<< 1) + w_e[1][g]
                       - (w_e[2][g] <<< 1) - w_e[2][g]);
        end
    end

    always_comb begin
        n_t = (i_curve_param > PARAM_W'(ONE_T)) ? PARAM_W'(ONE_T) : i_curve_param;
        for (int g = 0; g < 3; g++) begin
            w_r1[g] = (r_m1[g] + M1_W'(HALF_T)) >>> PARAM_FRAC_BITS;
            w_r2[g] = (r_m2[g] + M2_W'(HALF_T)) >>> PARAM_FRAC_BITS;
            w_r3[g] = (r_m3[g] + M3_W'(HALF_T)) >>> PARAM_FRAC_BITS;
            w_hr[g] = (r_h3[g] + H3_W'(1)) >>> 1;
            if (w_hr[g] > H3_W'(SAT_MAX)) begin
                n_pos[g] = COORD_WIDTH'(SAT_MAX);
            end else if (w_hr[g] < H3_W'(SAT_MIN)) begin
                n_pos[g] = COORD_WIDTH'(SAT_MIN);
            end else begin
                n_pos[g] = COORD_WIDTH'(w_hr[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[0] <= n_t;
            for (int s = 1; s < 5; s++) begin
                r_t[s] <= r_t[s-1];
            end
            for (int g = 0; g < 3; g++) begin
                r_m1[g]  <= M1_W'(r_a3[g]) * M1_W'($signed({1'b0, r_t[0]}));
                r_h1[g]  <= H1_W'(r_a2[g]) + H1_W'(w_r1[g]);
                r_m2[g]  <= M2_W'(r_h1[g]) * M2_W'($signed({1'b0, r_t[2]}));
                r_h2[g]  <= H2_W'(r_a1[g]) + H2_W'(w_r2[g]);
                r_m3[g]  <= M3_W'(r_h2[g]) * M3_W'($signed({1'b0, r_t[4]}));
                r_h3[g]  <= H3_W'(r_a0[g]) + H3_W'(w_r3[g]);
                r_pos[g] <= n_pos[g];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/cr3_checker.sv
`default_nettype none
module cr3_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic                                  o_stall,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_stall,
    input  wire logic signed [cr3_pkg::COORD_WIDTH-1:0] o_pos_x,
    input  wire logic signed [cr3_pkg::COORD_WIDTH-1:0] o_pos_y,
    input  wire logic signed [cr3_pkg::COORD_WIDTH-1:0] o_pos_z
);

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_pos_z)))
        else $error("stalled result changed or dropped");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && !$past(o_stall, 1) && !$past(o_stall, 2) && !$past(o_stall, 3)
            && !$past(o_stall, 4) && !$past(o_stall, 5) && !$past(o_stall, 6)
            && !$past(o_stall, 7) && !$past(o_stall, 8))
        |-> $past(i_valid && !o_stall, 8))
        else $error("result without matching request");

endmodule

bind catmull_rom_point_3d cr3_checker u_cr3_checker (.*);
`default_nettype wire

### bench/catmull_rom_point_3d_tb.sv
`default_nettype none
module catmull_rom_point_3d_tb;
    import cr3_pkg::*;

    localparam logic [PARAM_W-1:0] T_ONE = PARAM_W'(1 << PARAM_FRAC_BITS);
    localparam logic [PARAM_W-1:0] T_TOP = '1;
    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 100;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } pos_t;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;
    typedef enum logic [2:0] { MIX_ANY, MIX_RAILS, MIX_FLOOR, MIX_NEAR, MIX_EDGES } point_mix_e;

    typedef struct {
        row_kind_e                     kind;
        t_cfg_idx                      idx;
        logic [CP_W-1:0]               data;
        logic [PARAM_W-1:0]            t;
        bit                            lit;
        logic signed [COORD_WIDTH-1:0] ex;
        logic signed [COORD_WIDTH-1:0] ey;
        logic signed [COORD_WIDTH-1:0] ez;
    } dir_row_t;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [PARAM_W-1:0]            i_curve_param = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [COORD_WIDTH-1:0] o_pos_x;
    logic signed [COORD_WIDTH-1:0] o_pos_y;
    logic signed [COORD_WIDTH-1:0] o_pos_z;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CP_W-1:0]               i_cfg_data = '0;

    logic [CP_W-1:0] ctrl_pts [4] = '{default: '0};
    pos_t            points_due [$];
    int              mismatches = 0;
    bit              quiet = 1'b0;
    int              hold_asks = 0;
    int              hold_seen = 0;
    int              hold_left = 0;

    dir_row_t dir_rows [28] = '{
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h00000, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h10000, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h1FFFF, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_CFG, CFG_P1, 48'h0123_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P2, 48'h0123_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P3, 48'h0123_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P4, 48'h0123_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h00000, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh0123},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h0AAAA, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh0123},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h1FFFF, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh0123},
        '{ROW_CFG, CFG_P1, 48'h1111_2222_3333, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P2, 48'h1234_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P3, 48'hFEDC_7FFF_8000, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P4, 48'h0F0F_F0F0_5A5A, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h00000, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh1234},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h10000, 1'b1, 16'sh8000, 16'sh7FFF, -16'sh0124},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h10001, 1'b1, 16'sh8000, 16'sh7FFF, -16'sh0124},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h1FFFF, 1'b1, 16'sh8000, 16'sh7FFF, -16'sh0124},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h00001, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h08000, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h0FFFF, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_CFG, CFG_P1, 48'h0000_7FFF_8000, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P2, 48'h8000_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P3, 48'h7FFF_8000_7FFF, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_CFG, CFG_P4, 48'h0000_7FFF_8000, 17'h0, 1'b0, 16'sh0, 16'sh0, 16'sh0},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h08000, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h04000, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000},
        '{ROW_ITEM, CFG_P1, 48'h0, 17'h0C000, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000}
    };

    point_mix_e phase_mix [6] = '{MIX_ANY, MIX_RAILS, MIX_FLOOR, MIX_NEAR, MIX_ANY, MIX_EDGES};

    catmull_rom_point_3d DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_curve_param (i_curve_param),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] axis_value(input int axis,
                                                                 input longint tt);
        longint c [4];
        longint a0, a1, a2, a3, h;
        longint lo, hi;
        for (int k = 0; k < 4; k++) begin
            c[k] = longint'($signed(ctrl_pts[k][axis*COORD_WIDTH +: COORD_WIDTH]));
        end
        a0 = 2 * c[1];
        a1 = c[2] - c[0];
        a2 = 2 * c[0] - 5 * c[1] + 4 * c[2] - c[3];
        a3 = -c[0] + 3 * c[1] - 3 * c[2] + c[3];
        h  = a2 + half_up(a3 * tt, PARAM_FRAC_BITS);
        h  = a1 + half_up(h * tt, PARAM_FRAC_BITS);
        h  = a0 + half_up(h * tt, PARAM_FRAC_BITS);
        h  = half_up(h, 1);
        lo = -(longint'(1) << (COORD_WIDTH - 1));
        hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        if (h < lo) h = lo;
        if (h > hi) h = hi;
        return h[COORD_WIDTH-1:0];
    endfunction

    function automatic pos_t curve_point(input logic [PARAM_W-1:0] t);
        longint tt;
        pos_t   p;
        tt  = (t > T_ONE) ? longint'(T_ONE) : longint'(t);
        p.x = axis_value(0, tt);
        p.y = axis_value(1, tt);
        p.z = axis_value(2, tt);
        return p;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord(input point_mix_e mix);
        case (mix)
            MIX_RAILS: return $urandom_range(1) ? C_MAX : C_MIN;
            MIX_FLOOR: return C_MIN;
            MIX_NEAR:  return COORD_WIDTH'($urandom_range(1023) - 512);
            MIX_EDGES: begin
                case ($urandom_range(4))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return COORD_WIDTH'($urandom);
                endcase
            end
            default:   return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] rand_param();
        case ($urandom_range(9))
            0:       return '0;
            1:       return T_ONE;
            2:       return PARAM_W'($urandom_range(T_TOP, T_ONE + 1));
            default: return PARAM_W'($urandom_range(T_ONE - 1));
        endcase
    endfunction

    task automatic send_param(input logic [PARAM_W-1:0] t, input bit has_lit,
                              input pos_t lit);
        i_valid       <= 1'b1;
        i_curve_param <= t;
        do @(posedge i_clk); while (o_stall);
        if (has_lit) begin
            points_due.push_back(lit);
        end else begin
            points_due.push_back(curve_point(t));
        end
    endtask

    task automatic idle_gap();
        while (!quiet && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (points_due.size() != 0);
    endtask

    task automatic write_point(input t_cfg_idx idx, input logic [CP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ctrl_pts[idx] = data;
    endtask

    task automatic load_points(input point_mix_e mix);
        for (int k = 0; k < 4; k++) begin
            write_point(t_cfg_idx'(k), {rand_coord(mix), rand_coord(mix), rand_coord(mix)});
        end
        i_cfg_valid <= 1'b0;
    endtask

    // hold the output on request so the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            i_stall   <= 1'b1;
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 24);
        end
    end

    always @(posedge i_clk) begin
        pos_t want;
        pos_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_pos_x, o_pos_y, o_pos_z};
            if (points_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected point %0d %0d %0d", got.x, got.y, got.z);
                end
            end else begin
                want = points_due.pop_front();
                if (want.x !== got.x || want.y !== got.y || want.z !== got.z) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("point mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.x, want.y, want.z, got.x, got.y, got.z);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                if (!i_cfg_valid) drain();
                write_point(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                if (i_cfg_valid) i_cfg_valid <= 1'b0;
                send_param(dir_rows[r].t, dir_rows[r].lit,
                           pos_t'{dir_rows[r].ex, dir_rows[r].ey, dir_rows[r].ez});
                idle_gap();
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            load_points(phase_mix[ph]);
            quiet <= (ph == 1);
            if (ph == 3) hold_asks <= hold_asks + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) drain();
                send_param(rand_param(), 1'b0, pos_t'{'0, '0, '0});
                idle_gap();
            end
        end

        drain();
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (mismatches == 0 && points_due.size() == 0) begin
            $display("catmull_rom_point_3d_tb: done, clean");
        end else begin
            $display("catmull_rom_point_3d_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("catmull_rom_point_3d_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
